// File: sv/jsu_pkg.sv
// Shared types, constants and functions of the JSON string unescape unit.
package jsu_pkg;

  // Result kinds.
  localparam logic [2:0] K_DATA       = 3'd0;
  localparam logic [2:0] K_OK         = 3'd1;
  localparam logic [2:0] K_BAD_ESC    = 3'd2;
  localparam logic [2:0] K_BAD_CHAR   = 3'd3;
  localparam logic [2:0] K_BAD_HEX    = 3'd4;
  localparam logic [2:0] K_BAD_SURR   = 3'd5;
  localparam logic [2:0] K_MISS_QUOTE = 3'd6;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One job: up to four result words, sent in order from bytes[0].
  typedef struct packed {
    logic [2:0]      kind;
    logic [1:0]      nlast;
    logic [3:0][7:0] bytes;
  } job_t;

  function automatic job_t job_single(input logic [7:0] b, input logic [2:0] kind);
    job_t j;
    j.kind     = kind;
    j.nlast    = 2'd0;
    j.bytes    = '0;
    j.bytes[0] = b;
    return j;
  endfunction

  // UTF-8 encoding of a code point of at most 0x10FFFF.
  function automatic job_t job_utf8(input logic [20:0] code);
    job_t j;
    j.kind  = K_DATA;
    j.bytes = '0;
    if (code < 21'h80) begin
      j.nlast    = 2'd0;
      j.bytes[0] = {1'b0, code[6:0]};
    end else if (code < 21'h800) begin
      j.nlast    = 2'd1;
      j.bytes[0] = {3'b110, code[10:6]};
      j.bytes[1] = {2'b10, code[5:0]};
    end else if (code < 21'h10000) begin
      j.nlast    = 2'd2;
      j.bytes[0] = {4'b1110, code[15:12]};
      j.bytes[1] = {2'b10, code[11:6]};
      j.bytes[2] = {2'b10, code[5:0]};
    end else begin
      j.nlast    = 2'd3;
      j.bytes[0] = {5'b11110, code[20:18]};
      j.bytes[1] = {2'b10, code[17:12]};
      j.bytes[2] = {2'b10, code[11:6]};
      j.bytes[3] = {2'b10, code[5:0]};
    end
    return j;
  endfunction

  // Hex digit: bit 4 is set for a valid digit, bits 3:0 give its value.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// File: sv/jsu_front.sv
// Front end: parses each accepted byte and turns it into at most one job.
module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] in_byte,
  output logic       push,
  output job_t       job
);

  localparam logic [2:0] PH_AWAIT   = 3'd0;
  localparam logic [2:0] PH_BODY    = 3'd1;
  localparam logic [2:0] PH_ESC     = 3'd2;
  localparam logic [2:0] PH_HEX1    = 3'd3;
  localparam logic [2:0] PH_WANT_BS = 3'd4;
  localparam logic [2:0] PH_WANT_U  = 3'd5;
  localparam logic [2:0] PH_HEX2    = 3'd6;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  high_r, high_nxt;

  logic        fin;
  logic [2:0]  fin_kind;
  logic        emit;
  logic [20:0] emit_code;
  logic [4:0]  hv;
  logic [15:0] acc_new;

  assign hv      = hex_val(in_byte);
  assign acc_new = {acc_r[11:0], hv[3:0]};

  always_comb begin
    phase_nxt   = phase_r;
    hex_cnt_nxt = hex_cnt_r;
    acc_nxt     = acc_r;
    high_nxt    = high_r;
    fin         = 1'b0;
    fin_kind    = K_OK;
    emit        = 1'b0;
    emit_code   = '0;
    push        = 1'b0;
    job         = job_single(in_byte, K_DATA);
    if (acc) begin
      case (phase_r)
        PH_AWAIT: begin
          if (in_byte == CH_NUL) begin
            fin      = 1'b1;
            fin_kind = K_MISS_QUOTE;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (in_byte == CH_NUL) begin
            fin      = 1'b1;
            fin_kind = K_MISS_QUOTE;
          end else if (in_byte == CH_QUOTE) begin
            fin      = 1'b1;
            fin_kind = K_OK;
          end else if (in_byte == CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else if (in_byte < CH_SPACE) begin
            fin      = 1'b1;
            fin_kind = K_BAD_CHAR;
          end else begin
            push = 1'b1;
          end
        end
        PH_ESC: begin
          phase_nxt = PH_BODY;
          push      = 1'b1;
          case (in_byte)
            CH_B:      job = job_single(8'h08, K_DATA);
            CH_F:      job = job_single(8'h0C, K_DATA);
            CH_N:      job = job_single(8'h0A, K_DATA);
            CH_R:      job = job_single(8'h0D, K_DATA);
            CH_T:      job = job_single(8'h09, K_DATA);
            CH_SLASH,
            CH_QUOTE,
            CH_BSLASH: job = job_single(in_byte, K_DATA);
            CH_U: begin
              push        = 1'b0;
              phase_nxt   = PH_HEX1;
              hex_cnt_nxt = 2'd0;
              acc_nxt     = '0;
            end
            default: begin
              push     = 1'b0;
              fin      = 1'b1;
              fin_kind = K_BAD_ESC;
            end
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          if (!hv[4]) begin
            fin      = 1'b1;
            fin_kind = (phase_r == PH_HEX1) ? K_BAD_HEX : K_BAD_SURR;
          end else if (hex_cnt_r != 2'd3) begin
            acc_nxt     = acc_new;
            hex_cnt_nxt = hex_cnt_r + 2'd1;
          end else if (phase_r == PH_HEX1) begin
            if (acc_new[15:10] == 6'b110110) begin
              // High surrogate: keep its ten payload bits for the pair.
              high_nxt    = acc_new[9:0];
              acc_nxt     = '0;
              hex_cnt_nxt = 2'd0;
              phase_nxt   = PH_WANT_BS;
            end else begin
              emit      = 1'b1;
              emit_code = {5'd0, acc_new};
            end
          end else if (acc_new[15:10] != 6'b110111) begin
            fin      = 1'b1;
            fin_kind = K_BAD_SURR;
          end else begin
            emit      = 1'b1;
            emit_code = {1'b0, high_r, acc_new[9:0]} + 21'h10000;
          end
        end
        PH_WANT_BS: begin
          if (in_byte != CH_BSLASH) begin
            fin      = 1'b1;
            fin_kind = K_BAD_SURR;
          end else begin
            phase_nxt = PH_WANT_U;
          end
        end
        PH_WANT_U: begin
          if (in_byte != CH_U) begin
            fin      = 1'b1;
            fin_kind = K_BAD_SURR;
          end else begin
            phase_nxt   = PH_HEX2;
            hex_cnt_nxt = 2'd0;
            acc_nxt     = '0;
          end
        end
        default: begin
          phase_nxt   = PH_AWAIT;
          hex_cnt_nxt = 2'd0;
          acc_nxt     = '0;
          high_nxt    = '0;
        end
      endcase
      if (fin) begin
        phase_nxt   = PH_AWAIT;
        hex_cnt_nxt = 2'd0;
        acc_nxt     = '0;
        high_nxt    = '0;
        push        = 1'b1;
        job         = job_single(8'h00, fin_kind);
      end
      if (emit) begin
        phase_nxt   = PH_BODY;
        hex_cnt_nxt = 2'd0;
        acc_nxt     = '0;
        push        = 1'b1;
        job         = job_utf8(emit_code);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_AWAIT;
      hex_cnt_r <= 2'd0;
      acc_r     <= '0;
      high_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      acc_r     <= acc_nxt;
      high_r    <= high_nxt;
    end
  end

endmodule

// File: sv/jsu_queue.sv
// Short job queue between the parsing front and the output back end.
module jsu_queue import jsu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output job_t head
);

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + QAW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty) else $error("job popped from an empty queue");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != (QAW+1)'(QDEPTH)) |-> (cnt_r[QAW-1:0] == wp_r - rp_r))
    else $error("queue count disagrees with its pointers");

endmodule

// File: sv/jsu_back.sv
// Back end: expands each queued job into result words in an output register.
module jsu_back import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_nonempty,
  input  job_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_kind,
  output logic       out_last
);

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] byte_r;
  logic [2:0] kind_r;
  logic       last_r;
  logic       load;
  logic       is_last;

  assign load    = !valid_r || !out_stall;
  assign is_last = (idx_r == q_head.nlast);
  assign q_pop   = load && q_nonempty && is_last;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = q_nonempty;
      if (q_nonempty) begin
        idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_nonempty) begin
      byte_r <= q_head.bytes[idx_r];
      kind_r <= q_head.kind;
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_kind  = kind_r;
  assign out_last  = last_r;

  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r != K_DATA) |-> (last_r && byte_r == 8'h00))
    else $error("status word is not a lone zero word");

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> (q_nonempty && idx_r <= q_head.nlast))
    else $error("word index runs past the current job");

  a_idx_resets: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (idx_r == 2'd0))
    else $error("word index not cleared after a job is done");

endmodule

// File: sv/json_string_unescape_utf8_unit.sv
// Top level of the streaming JSON string unescape and UTF-8 encode unit.
//
//   channel | ports                                  | direction
//   input   | in_valid, in_stall, in_byte            | byte stream in
//   result  | out_valid, out_stall, out_byte,        | decoded words out
//           | out_kind, out_last                     |
//
// One byte is taken per cycle while the job queue has room; out_valid for an
// accepted byte rises at the earliest once its job has passed the queue and the
// output register. A \u escape or surrogate pair yields up to four words, sent
// one per cycle by the output register while out_stall is low, so the result
// side bounds the sustained rate. in_stall rises only when the four-entry job
// queue is full. Reset (rst_n low, synchronous) empties the queue and returns
// the parser to awaiting the opening quote.
module json_string_unescape_utf8_unit import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_kind,
  output logic       out_last
);

  logic acc;
  logic push;
  job_t push_job;
  logic q_full;
  logic q_nonempty;
  job_t q_head;
  logic q_pop;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_byte (in_byte),
    .push    (push),
    .job     (push_job)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_kind   (out_kind),
    .out_last   (out_last)
  );

endmodule

// File: dv/jsu_decode_checker.sv
// Checker that predicts the decoded words of the JSON string unescape unit and compares them.
module jsu_decode_checker import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic [2:0] out_kind,
  input  logic       out_last,
  output int         fail_count,
  output int         words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    AWAIT_QUOTE,
    IN_BODY,
    AFTER_BSLASH,
    FIRST_HEX,
    NEED_BSLASH,
    NEED_U,
    SECOND_HEX
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       last;
  } word_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  parse_phase_e phase_q;
  logic [1:0]   digits_read;
  logic [15:0]  unit_acc;
  logic [9:0]   high_bits;
  word_t        expected_words[$];
  word_t        got;
  word_t        want;

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  task automatic expect_word(input logic [7:0] data, input logic [2:0] kind, input logic last);
    word_t w;
    w.data = data;
    w.kind = kind;
    w.last = last;
    expected_words = {expected_words, w};
  endtask

  task automatic clear_parser();
    phase_q     = AWAIT_QUOTE;
    digits_read = '0;
    unit_acc    = '0;
    high_bits   = '0;
  endtask

  // Any status word ends the string and leaves the parser waiting for a new opening byte.
  task automatic close_string(input logic [2:0] kind);
    clear_parser();
    expect_word(8'h00, kind, 1'b1);
  endtask

  task automatic expect_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      expect_word(cp[7:0], K_DATA, 1'b1);
    end else if (cp < 21'h800) begin
      expect_word(8'hC0 | {3'd0, cp[10:6]}, K_DATA, 1'b0);
      expect_word(8'h80 | {2'd0, cp[5:0]}, K_DATA, 1'b1);
    end else if (cp < 21'h10000) begin
      expect_word(8'hE0 | {4'd0, cp[15:12]}, K_DATA, 1'b0);
      expect_word(8'h80 | {2'd0, cp[11:6]}, K_DATA, 1'b0);
      expect_word(8'h80 | {2'd0, cp[5:0]}, K_DATA, 1'b1);
    end else begin
      expect_word(8'hF0 | {5'd0, cp[20:18]}, K_DATA, 1'b0);
      expect_word(8'h80 | {2'd0, cp[17:12]}, K_DATA, 1'b0);
      expect_word(8'h80 | {2'd0, cp[11:6]}, K_DATA, 1'b0);
      expect_word(8'h80 | {2'd0, cp[5:0]}, K_DATA, 1'b1);
    end
    phase_q     = IN_BODY;
    digits_read = '0;
    unit_acc    = '0;
  endtask

  task automatic predict_byte(input logic [7:0] c);
    int d;
    d = hex_digit(c);
    case (phase_q)
      AWAIT_QUOTE: begin
        if (c == 8'h00) close_string(K_MISS_QUOTE);
        else phase_q = IN_BODY;
      end
      IN_BODY: begin
        if (c == 8'h00) close_string(K_MISS_QUOTE);
        else if (c == CH_QUOTE) close_string(K_OK);
        else if (c == CH_BSLASH) phase_q = AFTER_BSLASH;
        else if (c < 8'h20) close_string(K_BAD_CHAR);
        else expect_word(c, K_DATA, 1'b1);
      end
      AFTER_BSLASH: begin
        phase_q = IN_BODY;
        case (c)
          CH_B: expect_word(8'h08, K_DATA, 1'b1);
          CH_F: expect_word(8'h0C, K_DATA, 1'b1);
          CH_N: expect_word(8'h0A, K_DATA, 1'b1);
          CH_R: expect_word(8'h0D, K_DATA, 1'b1);
          CH_T: expect_word(8'h09, K_DATA, 1'b1);
          CH_SLASH, CH_QUOTE, CH_BSLASH: expect_word(c, K_DATA, 1'b1);
          CH_U: begin
            phase_q     = FIRST_HEX;
            digits_read = '0;
            unit_acc    = '0;
          end
          default: close_string(K_BAD_ESC);
        endcase
      end
      FIRST_HEX, SECOND_HEX: begin
        if (d < 0) begin
          close_string(phase_q == FIRST_HEX ? K_BAD_HEX : K_BAD_SURR);
        end else begin
          unit_acc = {unit_acc[11:0], d[3:0]};
          if (digits_read != 2'd3) begin
            digits_read = digits_read + 2'd1;
          end else begin
            digits_read = '0;
            if (phase_q == FIRST_HEX) begin
              // A high surrogate is held back until its low half has been read.
              if (unit_acc >= 16'hD800 && unit_acc < 16'hDC00) begin
                high_bits = 10'(unit_acc - 16'hD800);
                unit_acc  = '0;
                phase_q   = NEED_BSLASH;
              end else begin
                expect_utf8({5'd0, unit_acc});
              end
            end else if (unit_acc < 16'hDC00 || unit_acc >= 16'hE000) begin
              close_string(K_BAD_SURR);
            end else begin
              expect_utf8(21'h10000 + 21'(high_bits) * 21'h400 + 21'(unit_acc - 16'hDC00));
            end
          end
        end
      end
      NEED_BSLASH: begin
        if (c != CH_BSLASH) close_string(K_BAD_SURR);
        else phase_q = NEED_U;
      end
      NEED_U: begin
        if (c != CH_U) begin
          close_string(K_BAD_SURR);
        end else begin
          phase_q     = SECOND_HEX;
          digits_read = '0;
          unit_acc    = '0;
        end
      end
      default: clear_parser();
    endcase
  endtask

  // Sampling on the falling edge sees the values that the next rising edge will act on.
  always @(negedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.data = out_byte;
        got.kind = out_kind;
        got.last = out_last;
        if (expected_words.size() == 0) begin
          $error("word with nothing expected: out_byte %h out_kind %0d out_last %0d",
                 got.data, got.kind, got.last);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.data !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, got.data);
            fail_count++;
          end
          if (got.kind !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, got.last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_byte(in_byte);
    end
    words_due = expected_words.size();
  end

endmodule

// File: dv/tb_json_string_unescape_utf8_unit.sv
// Testbench top: feeds JSON string tokens into the unescape unit and gives the verdict.
module tb_json_string_unescape_utf8_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 200;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic       out_last;

  int         fail_count;
  int         words_due;
  int         cycle_count = 0;
  int         bytes_sent = 0;
  bit         calm_send = 1'b0;
  logic [7:0] token_bytes[$];

  always #5 clk = ~clk;

  json_string_unescape_utf8_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

  jsu_decode_checker decode_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_kind   (out_kind),
    .out_last   (out_last),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: a fresh stall is drawn for every word, with calm spells between.
  initial begin : take_words
    int   pause;
    int   taken;
    bit   calm_take;
    logic accepted;
    taken = 0;
    calm_take = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (taken % 48 == 0) calm_take = ($urandom_range(0, 2) == 0);
      pause = calm_take ? 0 : $urandom_range(0, 9);
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        accepted = rst_n && (out_valid === 1'b1);
        @(posedge clk);
      end while (!accepted);
      taken++;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int   pause;
    logic accepted;
    pause = calm_send ? 0 : $urandom_range(0, 9);
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do begin
      @(negedge clk);
      accepted = (in_stall === 1'b0);
      @(posedge clk);
    end while (!accepted);
  endtask

  task automatic send_token();
    foreach (token_bytes[i]) send_byte(token_bytes[i]);
    bytes_sent += token_bytes.size();
    token_bytes.delete();
  endtask

  task automatic wait_for_words();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  task automatic add_byte(input logic [7:0] b);
    token_bytes = {token_bytes, b};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'd0, n};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic bit is_escape(input logic [7:0] c);
    string letters = "bfnrt/\"\\";
    for (int i = 0; i < letters.len(); i++) begin
      if (c == letters[i]) return 1'b1;
    end
    return c == CH_U;
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_hex(c));
    return c;
  endfunction

  task automatic push_unit(input logic [15:0] v);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(v[i*4 +: 4]));
  endtask

  task automatic push_partial_unit();
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom_range(0, 15))));
    add_byte(bad_hex_char());
  endtask

  task automatic push_random_part();
    string      letters = "bfnrt/\"\\";
    logic [7:0] c;
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0, 1: begin
        do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == CH_QUOTE || c == CH_BSLASH);
        add_byte(c);
      end
      2: begin
        add_byte(CH_BSLASH);
        add_byte(letters[$urandom_range(0, 7)]);
      end
      3: begin
        // Anything but a high surrogate; the upper range takes in lone low surrogates.
        case ($urandom_range(0, 4))
          0: v = 16'($urandom_range(0, 16'h7F));
          1: v = 16'($urandom_range(16'h80, 16'h7FF));
          2: v = 16'($urandom_range(16'h800, 16'hD7FF));
          3: v = 16'($urandom_range(16'hDC00, 16'hFFFF));
          default: begin
            case ($urandom_range(0, 3))
              0: v = 16'h0000;
              1: v = 16'h07FF;
              2: v = 16'hDC00;
              default: v = 16'hFFFF;
            endcase
          end
        endcase
        push_unit(v);
      end
      default: begin
        case ($urandom_range(0, 5))
          0: begin
            push_unit(16'hD800);
            push_unit(16'hDC00);
          end
          1: begin
            push_unit(16'hDBFF);
            push_unit(16'hDFFF);
          end
          default: begin
            push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
            push_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
          end
        endcase
      end
    endcase
  endtask

  task automatic push_random_end();
    logic [7:0] c;
    case ($urandom_range(0, 19))
      0: add_byte(8'($urandom_range(1, 8'h1F)));
      1: add_byte(8'h00);
      2: begin
        do c = 8'($urandom_range(0, 255)); while (is_escape(c));
        add_byte(CH_BSLASH);
        add_byte(c);
      end
      3: push_partial_unit();
      4: begin
        push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
        do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH);
        add_byte(c);
      end
      5: begin
        push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
        add_byte(CH_BSLASH);
        do c = 8'($urandom_range(0, 255)); while (c == CH_U);
        add_byte(c);
      end
      6: begin
        push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
        push_partial_unit();
      end
      7: begin
        push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
        if ($urandom_range(0, 1)) push_unit(16'($urandom_range(0, 16'hDBFF)));
        else push_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
      end
      default: add_byte(CH_QUOTE);
    endcase
  endtask

  initial begin : stimulus
    bit paused;
    paused = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_byte  <= 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // End of text before any string, then a plain space, 0xFF and a raw control byte.
    add_byte(8'h00);
    push_text("\" ");
    add_byte(8'hFF);
    add_byte(8'h01);
    // The largest code point, an unknown escape, then a string cut off by end of text.
    push_text("\"\\uDBFF\\uDFFF\"");
    push_text("\"\\q");
    add_byte(CH_QUOTE);
    add_byte(8'h00);
    send_token();
    wait_for_words();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      calm_send = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_byte($urandom_range(0, 3) != 0 ? CH_QUOTE : 8'($urandom_range(1, 255)));
        repeat ($urandom_range(0, 6)) push_random_part();
        push_random_end();
      end
      send_token();
      if (!paused && bytes_sent >= RANDOM_BYTES / 2) begin
        wait_for_words();
        paused = 1'b1;
      end
    end

    wait_for_words();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/jsu_pkg.sv
sv/jsu_front.sv
sv/jsu_queue.sv
sv/jsu_back.sv
sv/json_string_unescape_utf8_unit.sv
dv/jsu_decode_checker.sv
dv/tb_json_string_unescape_utf8_unit.sv
